// ===== rtl/chi_pkg.sv =====
// Shared types and constants for the two-table cuckoo hash insert block.
// No dependencies; every other file in rtl/ uses this package.
package chi_pkg;

  localparam int TABLE_DEPTH_DEF    = 13;
  localparam int SECOND_MODULUS_DEF = 11;
  localparam int KEY_BITS_DEF       = 31;

  localparam int KICK_BITS       = 8;
  localparam int MAX_KICKS_RESET = 16;

  // bits consumed per cycle by the remainder units
  localparam int DIGIT_BITS = 8;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_CLEAR  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STAT_PLACED  = 2'd0,
    STAT_PRESENT = 2'd1,
    STAT_DROPPED = 2'd2,
    STAT_CLEARED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_HASH,
    ST_FOLD,
    ST_DECIDE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load_item;
    logic clear_tables;
    logic check;
    logic start_hash;
    logic start_fold;
    logic read;
    logic decide;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic limit;
    logic hash_done;
    logic fold_done;
    logic evict;
  } sts_t;

endpackage

// ===== rtl/chi_if.sv =====
// Valid/ready channel interfaces for the cuckoo hash insert block.
// Depends on chi_pkg for the op and status types.
interface chi_in_if #(
  parameter int KEY_BITS = chi_pkg::KEY_BITS_DEF
);
  logic                valid;
  logic                ready;
  chi_pkg::op_t        op;
  logic [KEY_BITS-1:0] key;

  modport source (output valid, output op, output key, input ready);
  modport sink   (input valid, input op, input key, output ready);
endinterface

interface chi_out_if #(
  parameter int KEY_BITS = chi_pkg::KEY_BITS_DEF
);
  logic                           valid;
  logic                           ready;
  chi_pkg::status_t               status;
  logic [KEY_BITS-1:0]            dropped_key;
  logic [chi_pkg::KICK_BITS-1:0]  kicks;

  modport source (output valid, output status, output dropped_key, output kicks, input ready);
  modport sink   (input valid, input status, input dropped_key, input kicks, output ready);
endinterface

interface chi_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [chi_pkg::KICK_BITS-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/cuckoo_hash_insert.sv =====
// Two-table cuckoo hash insert block. One item is worked on at a time; the result
// sits in an output register, so the next item is taken while it waits. A clear
// goes from acceptance to the finish state, which loads its result once the output
// register is free. An insert makes one placement attempt per eviction and one
// more; each attempt runs a limit check, the digit-serial remainder units that form
// the two indices, one registered table read and one compare/write step. An insert
// that reaches max_kicks ends at the limit check of the attempt that would follow.
// Valid bits are flip-flops, all cleared together by reset or a clear item.
// Depends on chi_pkg, chi_if, chi_ctrl, chi_datapath and chi_mod.
module cuckoo_hash_insert #(
  parameter int TABLE_DEPTH    = chi_pkg::TABLE_DEPTH_DEF,
  parameter int SECOND_MODULUS = chi_pkg::SECOND_MODULUS_DEF,
  parameter int KEY_BITS       = chi_pkg::KEY_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  chi_in_if.sink     in_ch,
  chi_out_if.source  out_ch,
  chi_cfg_if.sink    cfg_ch
);
  import chi_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ch.ready = 1'b1;

  chi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  chi_datapath #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .SECOND_MODULUS(SECOND_MODULUS),
    .KEY_BITS      (KEY_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_key         (in_ch.key),
    .cfg_we         (cfg_ch.valid),
    .cfg_data       (cfg_ch.data),
    .out_status     (out_ch.status),
    .out_dropped_key(out_ch.dropped_key),
    .out_kicks      (out_ch.kicks)
  );

endmodule

// ===== rtl/chi_mod.sv =====
// Digit-serial remainder unit: value mod MOD, DIGIT_BITS bits per cycle, MSB first.
// Depends on chi_pkg for DIGIT_BITS.
module chi_mod #(
  parameter int MOD   = chi_pkg::TABLE_DEPTH_DEF,
  parameter int WIDTH = chi_pkg::KEY_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [WIDTH-1:0]         value,
  output logic [$clog2(MOD)-1:0]   rem,
  output logic                     done
);
  import chi_pkg::*;

  localparam int NDIG = (WIDTH + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int PADW = NDIG * DIGIT_BITS;
  localparam int RW   = $clog2(MOD);
  localparam int CW   = $clog2(NDIG + 1);

  logic [PADW-1:0] shift_r;
  logic [RW-1:0]   rem_r, rem_step;
  logic [CW-1:0]   cnt_r;
  logic            busy_r, done_r;

  // r = (2r + bit) mod MOD, one conditional subtract per bit
  always_comb begin
    logic [RW:0]   t;
    logic [RW-1:0] r;
    r = rem_r;
    t = '0;
    for (int i = 0; i < DIGIT_BITS; i++) begin
      t = {r, shift_r[PADW-1-i]};
      if (t >= (RW+1)'(MOD)) t = t - (RW+1)'(MOD);
      r = t[RW-1:0];
    end
    rem_step = r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NDIG);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shift_r <= PADW'(value);
      rem_r   <= '0;
    end else if (busy_r) begin
      shift_r <= shift_r << DIGIT_BITS;
      rem_r   <= rem_step;
    end
  end

  assign rem  = rem_r;
  assign done = done_r;

endmodule

// ===== rtl/chi_datapath.sv =====
// Datapath: key tables, valid bits, hash units, kick counter and result registers.
// Depends on chi_pkg and chi_mod; driven by chi_ctrl through cmd_t / sts_t.
module chi_datapath #(
  parameter int TABLE_DEPTH    = chi_pkg::TABLE_DEPTH_DEF,
  parameter int SECOND_MODULUS = chi_pkg::SECOND_MODULUS_DEF,
  parameter int KEY_BITS       = chi_pkg::KEY_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  chi_pkg::cmd_t                 cmd,
  output chi_pkg::sts_t                 sts,
  input  logic [KEY_BITS-1:0]           in_key,
  input  logic                          cfg_we,
  input  logic [chi_pkg::KICK_BITS-1:0] cfg_data,
  output chi_pkg::status_t              out_status,
  output logic [KEY_BITS-1:0]           out_dropped_key,
  output logic [chi_pkg::KICK_BITS-1:0] out_kicks
);
  import chi_pkg::*;

  localparam int IW  = $clog2(TABLE_DEPTH);
  localparam int SW  = $clog2(SECOND_MODULUS + 1);
  localparam int R2W = $clog2(SECOND_MODULUS);

  logic [KEY_BITS-1:0]  cur_r;
  logic                 tbl_r;
  logic [KICK_BITS-1:0] cnt_r;
  logic [KICK_BITS-1:0] max_kicks_r;
  logic [IW-1:0]        p0_r, p1_r;
  logic [KEY_BITS-1:0]  rd0_r, rd1_r;
  logic [TABLE_DEPTH-1:0] vld0_r, vld1_r;

  logic [KEY_BITS-1:0] mem0 [TABLE_DEPTH];
  logic [KEY_BITS-1:0] mem1 [TABLE_DEPTH];

  status_t              res_status_r;
  logic [KEY_BITS-1:0]  res_drop_r;
  logic [KICK_BITS-1:0] res_kicks_r;

  status_t              out_status_r;
  logic [KEY_BITS-1:0]  out_drop_r;
  logic [KICK_BITS-1:0] out_kicks_r;

  logic [IW-1:0]  rem_first, rem_fold;
  logic [R2W-1:0] rem_second;
  logic [SW-1:0]  r2;
  logic           first_done, second_done, fold_done;

  chi_mod #(.MOD(TABLE_DEPTH), .WIDTH(KEY_BITS)) u_mod_first (
    .clk(clk), .rst_n(rst_n), .start(cmd.start_hash), .value(cur_r),
    .rem(rem_first), .done(first_done)
  );

  chi_mod #(.MOD(SECOND_MODULUS), .WIDTH(KEY_BITS)) u_mod_second (
    .clk(clk), .rst_n(rst_n), .start(cmd.start_hash), .value(cur_r),
    .rem(rem_second), .done(second_done)
  );

  // second index SM - (k mod SM), folded into the table range
  assign r2 = SW'(SECOND_MODULUS) - SW'(rem_second);

  chi_mod #(.MOD(TABLE_DEPTH), .WIDTH(SW)) u_mod_fold (
    .clk(clk), .rst_n(rst_n), .start(cmd.start_fold), .value(r2),
    .rem(rem_fold), .done(fold_done)
  );

  logic hit, tgt_vld;
  assign hit = (vld0_r[p0_r] && (rd0_r == cur_r)) ||
               (vld1_r[p1_r] && (rd1_r == cur_r));
  assign tgt_vld = tbl_r ? vld1_r[p1_r] : vld0_r[p0_r];

  logic wr0, wr1;
  assign wr0 = cmd.decide && !hit && !tbl_r;
  assign wr1 = cmd.decide && !hit &&  tbl_r;

  always_comb begin
    sts.limit     = (cnt_r == max_kicks_r);
    sts.hash_done = first_done && second_done;
    sts.fold_done = fold_done;
    sts.evict     = !hit && tgt_vld;
  end

  always_ff @(posedge clk) begin
    if (wr0) mem0[p0_r] <= cur_r;
    if (wr1) mem1[p1_r] <= cur_r;
    if (cmd.read) begin
      rd0_r <= mem0[rem_first];
      rd1_r <= mem1[rem_fold];
      p0_r  <= rem_first;
      p1_r  <= rem_fold;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r      <= '0;
      vld1_r      <= '0;
      max_kicks_r <= KICK_BITS'(MAX_KICKS_RESET);
    end else begin
      if (cfg_we) max_kicks_r <= cfg_data;
      if (cmd.clear_tables) begin
        vld0_r <= '0;
        vld1_r <= '0;
      end else begin
        if (wr0) vld0_r[p0_r] <= 1'b1;
        if (wr1) vld1_r[p1_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      cur_r <= in_key;
      tbl_r <= 1'b0;
      cnt_r <= '0;
    end else if (cmd.decide && !hit && tgt_vld) begin
      cur_r <= tbl_r ? rd1_r : rd0_r;
      tbl_r <= !tbl_r;
      cnt_r <= cnt_r + 1'b1;
    end

    if (cmd.clear_tables) begin
      res_status_r <= STAT_CLEARED;
      res_drop_r   <= '0;
      res_kicks_r  <= '0;
    end else if (cmd.check && sts.limit) begin
      res_status_r <= STAT_DROPPED;
      res_drop_r   <= cur_r;
      res_kicks_r  <= cnt_r;
    end else if (cmd.decide && !(!hit && tgt_vld)) begin
      // present only when the key in hand is the inserted one
      res_status_r <= (hit && cnt_r == '0) ? STAT_PRESENT : STAT_PLACED;
      res_drop_r   <= '0;
      res_kicks_r  <= cnt_r;
    end

    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_drop_r   <= res_drop_r;
      out_kicks_r  <= res_kicks_r;
    end
  end

  assign out_status      = out_status_r;
  assign out_dropped_key = out_drop_r;
  assign out_kicks       = out_kicks_r;

endmodule

// ===== rtl/chi_ctrl.sv =====
// Controller FSM for cuckoo hash insert: sequences limit check, hash, fold, read,
// compare/evict steps and owns the input ready and output valid. Depends on chi_pkg.
module chi_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  chi_pkg::op_t  in_op,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output chi_pkg::cmd_t cmd,
  input  chi_pkg::sts_t sts
);
  import chi_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = (in_op == OP_CLEAR) ? ST_FINISH : ST_CHECK;
      end
      ST_CHECK:  state_nxt = sts.limit ? ST_FINISH : ST_HASH;
      ST_HASH: begin
        if (sts.hash_done) state_nxt = ST_FOLD;
      end
      ST_FOLD: begin
        if (sts.fold_done) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: state_nxt = sts.evict ? ST_CHECK : ST_FINISH;
      ST_FINISH: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready         = 1'b1;
        cmd.load_item    = in_valid && (in_op == OP_INSERT);
        cmd.clear_tables = in_valid && (in_op == OP_CLEAR);
      end
      ST_CHECK: begin
        cmd.check      = 1'b1;
        cmd.start_hash = !sts.limit;
      end
      ST_HASH:   cmd.start_fold = sts.hash_done;
      ST_FOLD:   cmd.read       = sts.fold_done;
      ST_DECIDE: cmd.decide     = 1'b1;
      ST_FINISH: cmd.load_out   = out_free;
      default: ;
    endcase
  end

  always_comb begin
    if (cmd.load_out)   out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else                out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/chi_checker.sv =====
// Port-level assertions for cuckoo_hash_insert, attached by the bind below.
// Depends on chi_pkg for the op and status codes.
module chi_checker #(
  parameter int KEY_BITS = chi_pkg::KEY_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input chi_pkg::op_t                  in_op,
  input logic                          out_valid,
  input logic                          out_ready,
  input chi_pkg::status_t              out_status,
  input logic [KEY_BITS-1:0]           out_dropped_key,
  input logic [chi_pkg::KICK_BITS-1:0] out_kicks
);
  import chi_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_dropped_key) && $stable(out_kicks))
    else $error("result changed while stalled");

  // one item in flight at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("second item accepted while busy");

  // a clear taken with the output register empty reports a cleared result with zero kicks
  a_clear_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_op == OP_CLEAR) && !out_valid |-> ##2 out_valid &&
      (out_status == STAT_CLEARED) && (out_kicks == '0))
    else $error("clear result missing or wrong");

  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STAT_DROPPED) |-> out_dropped_key == '0)
    else $error("dropped key set on a non-drop result");

endmodule

bind cuckoo_hash_insert chi_checker #(.KEY_BITS(KEY_BITS)) u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_op          (in_ch.op),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_status     (out_ch.status),
  .out_dropped_key(out_ch.dropped_key),
  .out_kicks      (out_ch.kicks)
);

// ===== dv/tb_cuckoo_hash_insert.sv =====
// Self-checking bench for cuckoo_hash_insert: directed table, then random insert/clear runs.
// Keeps its own copy of both hash tables and the kick limit to predict each result that a directed row does not give.
// Depends on chi_pkg and the channel interfaces in chi_if.
module tb_cuckoo_hash_insert;
  import chi_pkg::*;

  localparam int KEY_W   = KEY_BITS_DEF;
  localparam int DEPTH   = TABLE_DEPTH_DEF;
  localparam int MODULUS = SECOND_MODULUS_DEF;

  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES   = 40;
  localparam longint      RUN_LIMIT     = 48_000_000;

  typedef struct packed {
    status_t          status;
    logic [KEY_W-1:0] dropped_key;
    logic [7:0]       kicks;
  } outcome_t;

  typedef enum logic { RK_ITEM, RK_CFG } row_kind_t;
  typedef enum logic [1:0] { RX_OPEN, RX_COIN, RX_SPARSE } rx_mode_t;

  typedef struct packed {
    row_kind_t        kind;
    op_t              op;
    logic [KEY_W-1:0] key;
    logic [7:0]       cap;
    logic             typed;
    outcome_t         want;
  } dir_row_t;

  localparam outcome_t NO_WANT = '0;

  logic clk;
  logic rst_n;

  chi_in_if  #(.KEY_BITS(KEY_W)) in_ch ();
  chi_out_if #(.KEY_BITS(KEY_W)) out_ch ();
  chi_cfg_if                     cfg_ch ();

  cuckoo_hash_insert dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // mirror of the block's tables and limit
  logic [KEY_W-1:0] keys0 [DEPTH];
  logic [KEY_W-1:0] keys1 [DEPTH];
  logic [DEPTH-1:0] used0;
  logic [DEPTH-1:0] used1;
  logic [7:0]       kick_cap;

  outcome_t    awaited_outcomes [$];
  int unsigned fails;
  int unsigned burst_left;
  int unsigned hold_seq;
  logic        row_typed;
  outcome_t    row_want;

  dir_row_t dir_rows [0:21] = '{
    '{RK_ITEM, OP_INSERT, 31'd0,          8'd0,   1'b1, '{STAT_PLACED,  31'd0, 8'd0}},
    '{RK_ITEM, OP_INSERT, 31'd0,          8'd0,   1'b1, '{STAT_PRESENT, 31'd0, 8'd0}},
    '{RK_ITEM, OP_INSERT, 31'h7FFF_FFFF,  8'd0,   1'b0, NO_WANT},
    '{RK_ITEM, OP_INSERT, 31'd13,         8'd0,   1'b0, NO_WANT},
    '{RK_ITEM, OP_INSERT, 31'd26,         8'd0,   1'b0, NO_WANT},
    '{RK_ITEM, OP_INSERT, 31'd0,          8'd0,   1'b0, NO_WANT},
    '{RK_ITEM, OP_INSERT, 31'h2AAA_AAAA,  8'd0,   1'b0, NO_WANT},
    '{RK_ITEM, OP_INSERT, 31'h5555_5555,  8'd0,   1'b0, NO_WANT},
    '{RK_ITEM, OP_CLEAR,  31'h7FFF_FFFF,  8'd0,   1'b1, '{STAT_CLEARED, 31'd0, 8'd0}},
    '{RK_ITEM, OP_INSERT, 31'd0,          8'd0,   1'b1, '{STAT_PLACED,  31'd0, 8'd0}},
    '{RK_CFG,  OP_INSERT, 31'd0,          8'd0,   1'b0, NO_WANT},
    '{RK_ITEM, OP_INSERT, 31'd5,          8'd0,   1'b1, '{STAT_DROPPED, 31'd5, 8'd0}},
    // key 0 is stored, but a zero limit drops it before the lookup
    '{RK_ITEM, OP_INSERT, 31'd0,          8'd0,   1'b1, '{STAT_DROPPED, 31'd0, 8'd0}},
    '{RK_ITEM, OP_INSERT, 31'h7FFF_FFFF,  8'd0,   1'b1,
      '{STAT_DROPPED, 31'h7FFF_FFFF, 8'd0}},
    '{RK_ITEM, OP_CLEAR,  31'd0,          8'd0,   1'b1, '{STAT_CLEARED, 31'd0, 8'd0}},
    '{RK_CFG,  OP_INSERT, 31'd0,          8'd1,   1'b0, NO_WANT},
    // multiples of 143 share both slots; under a limit of 1 each later one evicts and drops the one before
    '{RK_ITEM, OP_INSERT, 31'd143,        8'd0,   1'b0, NO_WANT},
    '{RK_ITEM, OP_INSERT, 31'd286,        8'd0,   1'b0, NO_WANT},
    '{RK_ITEM, OP_INSERT, 31'd429,        8'd0,   1'b0, NO_WANT},
    '{RK_CFG,  OP_INSERT, 31'd0,          8'd255, 1'b0, NO_WANT},
    '{RK_ITEM, OP_INSERT, 31'd0,          8'd0,   1'b0, NO_WANT},
    '{RK_ITEM, OP_INSERT, 31'd143,        8'd0,   1'b0, NO_WANT}
  };

  always #6 clk = ~clk;

  function automatic outcome_t wipe_tables();
    used0 = '0;
    used1 = '0;
    return '{STAT_CLEARED, '0, '0};
  endfunction

  function automatic outcome_t place_key(logic [KEY_W-1:0] key);
    outcome_t         res;
    logic [KEY_W-1:0] moving;
    logic [KEY_W-1:0] bumped;
    int unsigned      slot0;
    int unsigned      slot1;
    int unsigned      kicks_done;
    bit               in_second;
    bit               done;
    res        = '0;
    moving     = key;
    kicks_done = 0;
    in_second  = 1'b0;
    done       = 1'b0;
    while (!done) begin
      slot0 = moving % DEPTH;
      slot1 = MODULUS - (moving % MODULUS);
      if (slot1 >= DEPTH) slot1 = slot1 % DEPTH;
      res.kicks = 8'(kicks_done);
      if (kicks_done == kick_cap) begin
        res.status      = STAT_DROPPED;
        res.dropped_key = moving;
        done            = 1'b1;
      end else if ((used0[slot0] && keys0[slot0] == moving) ||
                   (used1[slot1] && keys1[slot1] == moving)) begin
        // an evicted key already in place still counts as a placement
        if (kicks_done == 0) res.status = STAT_PRESENT;
        else res.status = STAT_PLACED;
        done = 1'b1;
      end else if (!in_second && !used0[slot0]) begin
        keys0[slot0] = moving;
        used0[slot0] = 1'b1;
        done         = 1'b1;
      end else if (in_second && !used1[slot1]) begin
        keys1[slot1] = moving;
        used1[slot1] = 1'b1;
        done         = 1'b1;
      end else begin
        if (!in_second) begin
          bumped       = keys0[slot0];
          keys0[slot0] = moving;
        end else begin
          bumped       = keys1[slot1];
          keys1[slot1] = moving;
        end
        moving     = bumped;
        in_second  = !in_second;
        kicks_done = kicks_done + 1;
      end
    end
    return res;
  endfunction

  // Offers one transaction and returns at the edge that accepts it, or after the gap
  // that can end a burst; the sender runs in bursts, dropping valid only between bursts.
  task automatic offer(op_t op, logic [KEY_W-1:0] key, logic typed, outcome_t want);
    int unsigned gap;
    in_ch.valid <= 1'b1;
    in_ch.op    <= op;
    in_ch.key   <= key;
    row_typed   <= typed;
    row_want    <= want;
    do @(posedge clk); while (!in_ch.ready);
    if (burst_left > 0) burst_left = burst_left - 1;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) gap = 0;
      else if ($urandom_range(0, 9) == 0) gap = $urandom_range(10, 40);
      else gap = $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
  endtask

  // waits for an edge first so a transaction accepted at this edge is already queued
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaited_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cap(logic [7:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  always @(posedge clk) begin : watch_ports
    outcome_t calc;
    outcome_t want;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) kick_cap = cfg_ch.data;
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.op == OP_CLEAR) calc = wipe_tables();
        else calc = place_key(in_ch.key);
        awaited_outcomes.push_back(row_typed ? row_want : calc);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_outcomes.size() == 0) begin
          $display("%0t: unexpected result transaction status %0d key %0h kicks %0d",
                   $time, out_ch.status, out_ch.dropped_key, out_ch.kicks);
          fails = fails + 1;
        end else begin
          want = awaited_outcomes.pop_front();
          if (out_ch.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, out_ch.status);
            fails = fails + 1;
          end
          if (out_ch.dropped_key !== want.dropped_key) begin
            $display("%0t: dropped_key expected %0h actual %0h",
                     $time, want.dropped_key, out_ch.dropped_key);
            fails = fails + 1;
          end
          if (out_ch.kicks !== want.kicks) begin
            $display("%0t: kicks expected %0d actual %0d", $time, want.kicks, out_ch.kicks);
            fails = fails + 1;
          end
        end
      end
    end
  end

  // receiver: changing stall patterns plus one long hold-off on request
  initial begin : receiver
    rx_mode_t    mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned hold_seen;
    out_ch.ready = 1'b0;
    mode      = RX_OPEN;
    mode_left = 0;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left    = hold_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(20, 120);
        end else begin
          mode_left = mode_left - 1;
        end
        case (mode)
          RX_OPEN: out_ch.ready <= 1'b1;
          RX_COIN: out_ch.ready <= ($urandom_range(0, 1) == 1);
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    #(RUN_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int unsigned      phase_caps [8];
    int unsigned      quota;
    int unsigned      issued;
    int unsigned      run_len;
    int unsigned      pick;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] anchor;
    logic [KEY_W-1:0] used_keys [$];
    op_t              noise_op;
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.op     = OP_INSERT;
    in_ch.key    = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    row_typed    = 1'b0;
    row_want     = NO_WANT;
    hold_seq     = 0;
    fails        = 0;
    used0        = '0;
    used1        = '0;
    kick_cap     = 8'(MAX_KICKS_RESET);
    burst_left   = $urandom_range(1, 12);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == RK_CFG) begin
        settle();
        write_cap(dir_rows[i].cap);
      end else begin
        offer(dir_rows[i].op, dir_rows[i].key, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    phase_caps    = '{16, 1, 255, 2, 0, 5, 40, 0};
    phase_caps[7] = $urandom_range(2, 60);
    foreach (phase_caps[p]) begin
      settle();
      write_cap(8'(phase_caps[p]));
      // receiver stalls while the sender keeps pushing, so the input backs up
      if (p == 0) hold_seq <= hold_seq + 1;
      if (phase_caps[p] == 255) quota = 40;
      else if (phase_caps[p] == 0) quota = 30;
      else quota = 80;
      issued = 0;
      while (issued < quota) begin
        if ($urandom_range(0, 4) != 0) begin
          // clean run from empty tables, keys biased toward slot collisions
          offer(OP_CLEAR, KEY_W'($urandom()), 1'b0, NO_WANT);
          issued++;
          run_len = (phase_caps[p] == 255) ? $urandom_range(3, 8) : $urandom_range(3, 16);
          anchor  = KEY_W'($urandom_range(0, 32'h7FFF_0000));
          used_keys.delete();
          repeat (run_len) begin
            pick = $urandom_range(0, 9);
            if (pick < 3) key = KEY_W'(anchor + 143 * $urandom_range(0, 6));
            else if (pick < 5) key = KEY_W'(anchor + 13 * $urandom_range(0, 40));
            else if (pick < 7 && used_keys.size() > 0)
              key = used_keys[$urandom_range(0, used_keys.size() - 1)];
            else key = KEY_W'($urandom());
            used_keys.push_back(key);
            offer(OP_INSERT, key, 1'b0, NO_WANT);
            issued++;
          end
        end else begin
          noise_op = ($urandom_range(0, 7) == 0) ? OP_CLEAR : OP_INSERT;
          offer(noise_op, KEY_W'($urandom()), 1'b0, NO_WANT);
          issued++;
        end
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== cuckoo_hash_insert.f =====
rtl/chi_pkg.sv
rtl/chi_if.sv
rtl/chi_mod.sv
rtl/chi_datapath.sv
rtl/chi_ctrl.sv
rtl/cuckoo_hash_insert.sv
rtl/chi_checker.sv
dv/tb_cuckoo_hash_insert.sv
